>>> hw/rtl/cbq_pkg.sv
// Shared constants, types and register codes of the cascaded biquad IIR filter.
`timescale 1ns / 1ps

package cbq_pkg;

  localparam int unsigned Channels     = 8;
  localparam int unsigned SampleBits   = 24;
  localparam int unsigned CoefFracBits = 21;

  localparam int unsigned ChannelBits  = 3;
  localparam int unsigned CoefBits     = 24;
  localparam int unsigned StateBits    = 40;
  localparam int unsigned SectionBits  = 2;
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 24;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [CfgIndexBits-1:0] {
    RegA0       = 3'd0,
    RegA1       = 3'd1,
    RegA2       = 3'd2,
    RegB1       = 3'd3,
    RegB2       = 3'd4,
    RegSections = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoefBits-1:0] a0;
    logic signed [CoefBits-1:0] a1;
    logic signed [CoefBits-1:0] a2;
    logic signed [CoefBits-1:0] b1;
    logic signed [CoefBits-1:0] b2;
  } coef_t;

  typedef struct packed {
    logic                   chan_ok;
    logic                   two_sections;
    logic [ChannelBits-1:0] channel;
  } item_tag_t;

endpackage

>>> hw/rtl/cbq_if.sv
// Channel interfaces of the cascaded biquad IIR filter: input, output and configuration.
`timescale 1ns / 1ps

interface cbq_in_if #(
  parameter int unsigned SampleBits = cbq_pkg::SampleBits
);
  logic                                 valid;
  logic                                 ready;
  logic        [cbq_pkg::ChannelBits-1:0] channel;
  logic signed [SampleBits-1:0]         sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface cbq_out_if #(
  parameter int unsigned SampleBits = cbq_pkg::SampleBits
);
  logic                                 valid;
  logic                                 ready;
  logic        [cbq_pkg::ChannelBits-1:0] channel_out;
  logic signed [SampleBits-1:0]         sample_out;
  logic                                 clipped;

  modport source (output valid, output channel_out, output sample_out, output clipped,
                  input ready);
  modport sink (input valid, input channel_out, input sample_out, input clipped,
                output ready);
endinterface

interface cbq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbq_pkg::CfgIndexBits-1:0] index;
  logic [cbq_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/cbq_front.sv
// Front end: accepts input transfers, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module cbq_front #(
  parameter int unsigned Channels   = cbq_pkg::Channels,
  parameter int unsigned SampleBits = cbq_pkg::SampleBits,
  localparam int unsigned QBits     = $bits(cbq_pkg::item_tag_t) + SampleBits
) (
  cbq_in_if.sink                         in_i,
  input  logic [cbq_pkg::SectionBits-1:0] section_count_i,
  input  logic                           full_i,
  output logic                           push_o,
  output logic [QBits-1:0]               data_o
);

  cbq_pkg::item_tag_t tag;

  always_comb begin
    tag.chan_ok      = (32'(in_i.channel) < Channels);
    tag.two_sections = section_count_i[1];
    tag.channel      = in_i.channel;
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign data_o     = {tag, in_i.sample_in};

endmodule

>>> hw/rtl/cbq_fifo.sv
// Short queue between the front end and the filter engine.
`timescale 1ns / 1ps

module cbq_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = cbq_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountBits = $clog2(Depth + 1);

  logic [Width-1:0]     mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountBits-1:0] count_q;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] ptr);
    next_ptr = (ptr == PtrBits'(Depth - 1)) ? '0 : ptr + PtrBits'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CountBits'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CountBits'(Depth));
  assign empty_o = (count_q == '0);

endmodule

>>> hw/rtl/cbq_back.sv
// Filter engine: sequencer, shared multiplier, delay state memory and output register.
`timescale 1ns / 1ps

module cbq_back #(
  parameter int unsigned Channels     = cbq_pkg::Channels,
  parameter int unsigned SampleBits   = cbq_pkg::SampleBits,
  parameter int unsigned CoefFracBits = cbq_pkg::CoefFracBits,
  localparam int unsigned QBits       = $bits(cbq_pkg::item_tag_t) + SampleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  logic [QBits-1:0]   data_i,
  output logic               pop_o,
  input  cbq_pkg::coef_t     coef_i,
  cbq_out_if.source          out_o
);

  localparam int unsigned StateBits  = cbq_pkg::StateBits;
  localparam int unsigned CoefBits   = cbq_pkg::CoefBits;
  localparam int unsigned TagBits    = $bits(cbq_pkg::item_tag_t);
  localparam int unsigned StateFrac  = StateBits - SampleBits - 3;
  localparam int unsigned ShiftRight = (CoefFracBits > StateFrac) ?
                                       CoefFracBits - StateFrac : 0;
  localparam int unsigned ShiftLeft  = (StateFrac > CoefFracBits) ?
                                       StateFrac - CoefFracBits : 0;
  localparam int unsigned ProdBits   = SampleBits + CoefBits;
  localparam int unsigned AlignBits  = ProdBits + ShiftLeft + 1;
  localparam int unsigned AccBits    = ((AlignBits > StateBits) ? AlignBits : StateBits) + 2;
  localparam int unsigned Entries    = 2 * Channels;
  localparam int unsigned AddrBits   = $clog2(Entries);

  localparam logic signed [AccBits-1:0] AlignHalf = (ShiftRight > 0) ?
      (AccBits'(1) << ((ShiftRight > 0) ? ShiftRight - 1 : 0)) : '0;
  localparam logic signed [AccBits-1:0] RoundHalf = AccBits'(1) << (StateFrac - 1);
  localparam logic signed [AccBits-1:0] SampleMax =
      AccBits'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
  localparam logic signed [AccBits-1:0] SampleMin = ~SampleMax;
  localparam logic signed [AccBits-1:0] StateMax =
      AccBits'((64'sd1 <<< (StateBits - 1)) - 64'sd1);
  localparam logic signed [AccBits-1:0] StateMin = ~StateMax;

  typedef enum logic [9:0] {
    StIdle  = 10'b00_0000_0001,
    StRead  = 10'b00_0000_0010,
    StMul0  = 10'b00_0000_0100,
    StMul1  = 10'b00_0000_1000,
    StMul2  = 10'b00_0001_0000,
    StMul3  = 10'b00_0010_0000,
    StMul4  = 10'b00_0100_0000,
    StMul5  = 10'b00_1000_0000,
    StWrite = 10'b01_0000_0000,
    StOut   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  cbq_pkg::item_tag_t          q_tag;
  logic signed [SampleBits-1:0] q_sample;

  logic [cbq_pkg::ChannelBits-1:0] ch_q;
  logic                            two_q;
  logic                            sec_q;
  logic [AddrBits-1:0]             addr_q;
  logic signed [SampleBits-1:0]    x_q;
  logic signed [SampleBits-1:0]    y_q;
  logic                            clip_q;

  logic signed [SampleBits-1:0] mul_a;
  logic signed [CoefBits-1:0]   mul_b;
  logic signed [ProdBits-1:0]   prod_d, prod_q;
  logic signed [AccBits-1:0]    acc_q, n1_q, n2_q;
  logic signed [AccBits-1:0]    round_v;
  logic signed [SampleBits-1:0] y_sat;
  logic                         y_hit;

  logic signed [StateBits-1:0] d1_mem [Entries];
  logic signed [StateBits-1:0] d2_mem [Entries];
  logic [Entries-1:0]          vld_q;
  logic signed [StateBits-1:0] d1_rd_q, d2_rd_q;
  logic                        vld_rd_q;
  logic signed [StateBits-1:0] d1_eff, d2_eff;

  logic                                 out_valid_q;
  logic [cbq_pkg::ChannelBits-1:0]      out_ch_q;
  logic signed [SampleBits-1:0]         out_sample_q;
  logic                                 out_clip_q;
  logic                                 out_load;
  logic                                 more_sections;

  function automatic logic signed [AccBits-1:0] align_prod(
    input logic signed [ProdBits-1:0] p
  );
    logic signed [AccBits-1:0] ext;
    ext = AccBits'(p);
    if (ShiftRight > 0) begin
      align_prod = (ext + AlignHalf) >>> ShiftRight;
    end else begin
      align_prod = ext <<< ShiftLeft;
    end
  endfunction

  function automatic logic signed [StateBits-1:0] sat_state(
    input logic signed [AccBits-1:0] v
  );
    logic signed [AccBits-1:0] c;
    if (v > StateMax) begin
      c = StateMax;
    end else if (v < StateMin) begin
      c = StateMin;
    end else begin
      c = v;
    end
    sat_state = StateBits'(c);
  endfunction

  assign q_tag    = cbq_pkg::item_tag_t'(data_i[QBits-1 -: TagBits]);
  assign q_sample = data_i[SampleBits-1:0];

  assign d1_eff = vld_rd_q ? d1_rd_q : '0;
  assign d2_eff = vld_rd_q ? d2_rd_q : '0;

  always_comb begin
    round_v = (acc_q + RoundHalf) >>> StateFrac;
    y_hit   = 1'b0;
    if (round_v > SampleMax) begin
      y_sat = SampleBits'(SampleMax);
      y_hit = 1'b1;
    end else if (round_v < SampleMin) begin
      y_sat = SampleBits'(SampleMin);
      y_hit = 1'b1;
    end else begin
      y_sat = SampleBits'(round_v);
    end
  end

  always_comb begin
    mul_a = x_q;
    mul_b = $signed(coef_i.a0);
    unique case (state_q)
      StMul1: mul_b = $signed(coef_i.a1);
      StMul2: mul_b = $signed(coef_i.a2);
      StMul3: begin
        mul_a = y_q;
        mul_b = $signed(coef_i.b1);
      end
      StMul4: begin
        mul_a = y_q;
        mul_b = $signed(coef_i.b2);
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  assign out_load      = (state_q == StOut) && (!out_valid_q || out_o.ready);
  assign more_sections = two_q && !sec_q;
  assign pop_o         = (state_q == StIdle) && !empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = q_tag.chan_ok ? StRead : StOut;
        end
      end
      StRead:  state_d = StMul0;
      StMul0:  state_d = StMul1;
      StMul1:  state_d = StMul2;
      StMul2:  state_d = StMul3;
      StMul3:  state_d = StMul4;
      StMul4:  state_d = StMul5;
      StMul5:  state_d = StWrite;
      StWrite: state_d = more_sections ? StRead : StOut;
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StWrite) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          ch_q   <= q_tag.channel;
          two_q  <= q_tag.two_sections;
          sec_q  <= 1'b0;
          x_q    <= q_sample;
          y_q    <= '0;
          clip_q <= 1'b0;
          addr_q <= AddrBits'(q_tag.channel);
        end
      end
      StRead: begin
        d1_rd_q  <= d1_mem[addr_q];
        d2_rd_q  <= d2_mem[addr_q];
        vld_rd_q <= vld_q[addr_q];
      end
      StMul1: acc_q <= align_prod(prod_q) + AccBits'(d1_eff);
      StMul2: begin
        y_q    <= y_sat;
        clip_q <= clip_q | y_hit;
        n1_q   <= align_prod(prod_q) + AccBits'(d2_eff);
      end
      StMul3: n2_q <= align_prod(prod_q);
      StMul4: n1_q <= n1_q - align_prod(prod_q);
      StMul5: n2_q <= n2_q - align_prod(prod_q);
      StWrite: begin
        d1_mem[addr_q] <= sat_state(n1_q);
        d2_mem[addr_q] <= sat_state(n2_q);
        if (more_sections) begin
          sec_q  <= 1'b1;
          x_q    <= y_q;
          addr_q <= AddrBits'(ch_q) + AddrBits'(Channels);
        end
      end
      StOut: begin
        if (out_load) begin
          out_ch_q     <= ch_q;
          out_sample_q <= y_q;
          out_clip_q   <= clip_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.sample_out  = out_sample_q;
  assign out_o.clipped     = out_clip_q;

endmodule

>>> hw/rtl/cascaded_biquad_iir_filter.sv
// Top level of the multichannel cascaded biquad IIR filter with its configuration registers.
// A sample moves from queue to output register through a state memory read, five products on
// the single shared multiplier and a state write back per section, with one or two sections;
// a sample on a channel beyond the channel count skips these steps and passes out as zero.
// A two-entry queue lets the input side keep accepting while the engine works, and the output
// register holds a finished result while the engine starts the next sample. Delay state reads
// as zero after reset through per-entry valid bits, so no clearing pass is needed.
// Coefficients and the section count should only be written while no sample is in flight.
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter #(
  parameter int unsigned Channels     = cbq_pkg::Channels,
  parameter int unsigned SampleBits   = cbq_pkg::SampleBits,
  parameter int unsigned CoefFracBits = cbq_pkg::CoefFracBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbq_in_if.sink     in_i,
  cbq_out_if.source  out_o,
  cbq_cfg_if.sink    cfg_i
);

  localparam int unsigned QBits = $bits(cbq_pkg::item_tag_t) + SampleBits;

  cbq_pkg::coef_t                  coef_q;
  logic [cbq_pkg::SectionBits-1:0] sections_q;

  logic             q_push, q_full, q_pop, q_empty;
  logic [QBits-1:0] q_wdata, q_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q     <= '0;
      sections_q <= cbq_pkg::SectionBits'(1);
    end else if (cfg_i.valid) begin
      unique case (cbq_pkg::cfg_reg_e'(cfg_i.index))
        cbq_pkg::RegA0:       coef_q.a0  <= cfg_i.data[cbq_pkg::CoefBits-1:0];
        cbq_pkg::RegA1:       coef_q.a1  <= cfg_i.data[cbq_pkg::CoefBits-1:0];
        cbq_pkg::RegA2:       coef_q.a2  <= cfg_i.data[cbq_pkg::CoefBits-1:0];
        cbq_pkg::RegB1:       coef_q.b1  <= cfg_i.data[cbq_pkg::CoefBits-1:0];
        cbq_pkg::RegB2:       coef_q.b2  <= cfg_i.data[cbq_pkg::CoefBits-1:0];
        cbq_pkg::RegSections: sections_q <= cfg_i.data[cbq_pkg::SectionBits-1:0];
        default: ;
      endcase
    end
  end

  cbq_front #(
    .Channels   (Channels),
    .SampleBits (SampleBits)
  ) u_front (
    .in_i            (in_i),
    .section_count_i (sections_q),
    .full_i          (q_full),
    .push_o          (q_push),
    .data_o          (q_wdata)
  );

  cbq_fifo #(
    .Width (QBits),
    .Depth (cbq_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  cbq_back #(
    .Channels     (Channels),
    .SampleBits   (SampleBits),
    .CoefFracBits (CoefFracBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .data_i  (q_rdata),
    .pop_o   (q_pop),
    .coef_i  (coef_q),
    .out_o   (out_o)
  );

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Engine took an item from an empty queue.");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("Front end pushed into a full queue.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.channel_out) && $stable(out_o.sample_out) &&
       $stable(out_o.clipped)))
    else $error("Result changed while it waited for a transfer.");

  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (32'(out_o.channel_out) >= Channels)) |->
      (out_o.sample_out == '0 && !out_o.clipped))
    else $error("Result for an unused channel is not zero.");

endmodule

>>> sim/tb_cascaded_biquad_iir_filter.sv
// Self-checking testbench for the cascaded biquad IIR filter with a built-in filter predictor.
`timescale 1ns / 1ps

module tb_cascaded_biquad_iir_filter;

  localparam int unsigned Channels     = cbq_pkg::Channels;
  localparam int unsigned SampleBits   = cbq_pkg::SampleBits;
  localparam int unsigned CoefFracBits = cbq_pkg::CoefFracBits;
  localparam int unsigned ChannelBits  = cbq_pkg::ChannelBits;
  localparam int unsigned CoefBits     = cbq_pkg::CoefBits;
  localparam int unsigned StateBits    = cbq_pkg::StateBits;
  localparam int unsigned SectionBits  = cbq_pkg::SectionBits;
  localparam int unsigned CfgIndexBits = cbq_pkg::CfgIndexBits;
  localparam int unsigned CfgDataBits  = cbq_pkg::CfgDataBits;

  localparam int StateFrac = int'(StateBits) - int'(SampleBits) - 3;
  localparam logic [CfgIndexBits-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIndexBits-1:0] RegSpareHi = 3'd7;
  localparam logic [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [CoefBits-1:0] CoefMax = {1'b0, {(CoefBits-1){1'b1}}};
  localparam logic [CoefBits-1:0] CoefMin = {1'b1, {(CoefBits-1){1'b0}}};
  localparam logic [CoefBits-1:0] CoefUnity = CoefBits'(1) << CoefFracBits;
  localparam int BlockItems = 25;

  typedef struct packed {
    logic [ChannelBits-1:0] channel;
    logic [SampleBits-1:0]  sample;
    logic                   clipped;
  } filt_out_t;

  logic clk;
  logic rst_n;

  cbq_in_if  in_if ();
  cbq_out_if out_if ();
  cbq_cfg_if cfg_if ();

  cascaded_biquad_iir_filter DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  longint gain_a0, gain_a1, gain_a2, gain_b1, gain_b2;
  logic [SectionBits-1:0] section_sel;
  longint hist_one[2*Channels];
  longint hist_two[2*Channels];

  filt_out_t pending_outputs[$];
  int mismatches;
  int idle_pct;
  int stall_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd4_800_000);
    $display("cascaded_biquad_iir_filter verification failed");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint align_product(longint p);
    if (int'(CoefFracBits) > StateFrac) return round_shift(p, int'(CoefFracBits) - StateFrac);
    return p * (longint'(1) << (StateFrac - int'(CoefFracBits)));
  endfunction

  function automatic longint clamp_bits(longint v, int bits, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint biquad_stage(int idx, longint x, inout bit clip);
    bit     unused;
    longint acc;
    longint y;
    longint n1;
    longint n2;
    unused = 1'b0;
    acc = align_product(x * gain_a0) + hist_one[idx];
    y   = clamp_bits(round_shift(acc, StateFrac), SampleBits, clip);
    n1  = align_product(x * gain_a1) + hist_two[idx] - align_product(gain_b1 * y);
    n2  = align_product(x * gain_a2) - align_product(gain_b2 * y);
    hist_one[idx] = clamp_bits(n1, StateBits, unused);
    hist_two[idx] = clamp_bits(n2, StateBits, unused);
    return y;
  endfunction

  function automatic filt_out_t filter_predict(logic [ChannelBits-1:0] ch,
                                               logic signed [SampleBits-1:0] x);
    filt_out_t r;
    bit        clip;
    longint    y;
    clip = 1'b0;
    y = 0;
    if (ch < Channels) begin
      y = biquad_stage(int'(ch), longint'(x), clip);
      if (section_sel >= 2) y = biquad_stage(int'(Channels) + int'(ch), y, clip);
    end
    r.channel = ch;
    r.sample  = SampleBits'(y);
    r.clipped = clip;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] d);
    case (idx)
      cbq_pkg::RegA0:       gain_a0 = longint'(signed'(d[CoefBits-1:0]));
      cbq_pkg::RegA1:       gain_a1 = longint'(signed'(d[CoefBits-1:0]));
      cbq_pkg::RegA2:       gain_a2 = longint'(signed'(d[CoefBits-1:0]));
      cbq_pkg::RegB1:       gain_b1 = longint'(signed'(d[CoefBits-1:0]));
      cbq_pkg::RegB2:       gain_b2 = longint'(signed'(d[CoefBits-1:0]));
      cbq_pkg::RegSections: section_sel = d[SectionBits-1:0];
      default: begin
      end
    endcase
  endfunction

  function automatic logic [SampleBits-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SampleMax : SampleMin;
      1, 2:    return SampleBits'($urandom_range(0, 511) - 256);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  function automatic logic [CoefBits-1:0] rand_coef(bit wide, int frac_range);
    if (wide) return CoefBits'($urandom);
    return CoefBits'($urandom_range(0, 2 * frac_range) - frac_range);
  endfunction

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transfer: ch %0d sample %0d clipped %0d", out_if.channel_out,
                   out_if.sample_out, out_if.clipped);
      end else begin
        want = pending_outputs.pop_front();
        if (out_if.channel_out !== want.channel || out_if.sample_out !== want.sample ||
            out_if.clipped !== want.clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected ch %0d sample %0d clipped %0d, ",
                      "got ch %0d sample %0d clipped %0d"},
                     want.channel, $signed(want.sample), want.clipped, out_if.channel_out,
                     out_if.sample_out, out_if.clipped);
        end
      end
    end
  end

  task automatic send_sample(logic [ChannelBits-1:0] ch, logic [SampleBits-1:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.channel   = ch;
    in_if.sample_in = x;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_outputs.push_back(filter_predict(ch, x));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic load_coefs(logic [CoefBits-1:0] a0, logic [CoefBits-1:0] a1,
                            logic [CoefBits-1:0] a2, logic [CoefBits-1:0] b1,
                            logic [CoefBits-1:0] b2, logic [CfgDataBits-1:0] sec);
    wait_drained();
    write_reg(cbq_pkg::RegA0, a0);
    write_reg(cbq_pkg::RegA1, a1);
    write_reg(cbq_pkg::RegA2, a2);
    write_reg(cbq_pkg::RegB1, b1);
    write_reg(cbq_pkg::RegB2, b2);
    write_reg(cbq_pkg::RegSections, sec);
    cfg_if.valid = 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(3'd0, SampleMax);
    send_sample(3'd7, SampleMin);
    send_sample(3'd2, SampleBits'(12345));
  endtask

  task automatic test_passthrough_extremes();
    load_coefs(CoefUnity, '0, '0, '0, '0, CfgDataBits'(1));
    send_sample(3'd0, SampleMax);
    send_sample(3'd7, SampleMin);
    send_sample(3'd1, '0);
    send_sample(3'd6, '1);
    send_sample(3'd3, SampleBits'(1));
  endtask

  task automatic test_output_clipping();
    load_coefs(CoefMax, '0, '0, '0, '0, CfgDataBits'(1));
    send_sample(3'd4, SampleMax);
    send_sample(3'd5, SampleMin);
    load_coefs(CoefMin, '0, '0, '0, '0, CfgDataBits'(1));
    send_sample(3'd4, SampleMin);
    send_sample(3'd5, SampleMax);
  endtask

  task automatic test_section_count_codes();
    // A count of zero acts as one section, three acts as two; upper data bits are ignored.
    load_coefs(CoefUnity, CoefBits'(32'h0C0000), CoefBits'(32'hF40000),
               CoefBits'(32'h100000), CoefBits'(32'hFA0000), {22'h2AAAAA, 2'd0});
    send_sample(3'd1, SampleBits'(1000000));
    send_sample(3'd1, SampleBits'(-2000000));
    wait_drained();
    write_reg(cbq_pkg::RegSections, {22'h155555, 2'd2});
    cfg_if.valid = 1'b0;
    send_sample(3'd2, SampleBits'(3000000));
    send_sample(3'd2, SampleBits'(-700000));
    wait_drained();
    write_reg(cbq_pkg::RegSections, {22'h3FFFFF, 2'd3});
    // Writes beyond the register list must leave every setting alone.
    write_reg(RegSpareLo, CfgDataBits'(32'h800000));
    write_reg(RegSpareHi, '1);
    cfg_if.valid = 1'b0;
    send_sample(3'd2, SampleBits'(4000000));
    send_sample(3'd6, SampleBits'(-4000000));
  endtask

  task automatic test_state_saturation();
    load_coefs(CoefMax, CoefMax, CoefMax, CoefMin, CoefMin, CfgDataBits'(1));
    repeat (3) send_sample(3'd5, SampleMax);
    repeat (2) send_sample(3'd5, SampleMin);
  endtask

  task automatic test_random_traffic(int sender_idle, int receiver_stall, int blocks);
    bit wide;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int b = 0; b < blocks; b++) begin
      wide = ($urandom_range(3) == 0);
      load_coefs(rand_coef(wide, 1 << 21), rand_coef(wide, 1 << 22), rand_coef(wide, 1 << 21),
                 rand_coef(wide, 1 << 22), rand_coef(wide, 1 << 20), CfgDataBits'($urandom));
      for (int i = 0; i < BlockItems; i++)
        send_sample(ChannelBits'($urandom), rand_sample());
    end
  endtask

  task automatic test_output_backpressure();
    load_coefs(CoefUnity, CoefBits'(32'h080000), '0, CoefBits'(32'hF80000), '0,
               CfgDataBits'(2));
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 40; i++) send_sample(ChannelBits'($urandom), rand_sample());
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.channel    = '0;
    in_if.sample_in  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    mismatches       = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_left        = 0;
    gain_a0          = 0;
    gain_a1          = 0;
    gain_a2          = 0;
    gain_b1          = 0;
    gain_b2          = 0;
    section_sel      = SectionBits'(1);
    for (int i = 0; i < 2 * Channels; i++) begin
      hist_one[i] = 0;
      hist_two[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_passthrough_extremes();
    test_output_clipping();
    test_section_count_codes();
    test_state_saturation();
    test_random_traffic(0, 0, 6);
    test_random_traffic(51, 0, 6);
    test_random_traffic(0, 51, 6);
    test_random_traffic(31, 31, 6);
    test_output_backpressure();

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("cascaded_biquad_iir_filter verification clean");
    end else begin
      $display("cascaded_biquad_iir_filter verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cbq_pkg.sv
hw/rtl/cbq_if.sv
hw/rtl/cbq_front.sv
hw/rtl/cbq_fifo.sv
hw/rtl/cbq_back.sv
hw/rtl/cascaded_biquad_iir_filter.sv
sim/tb_cascaded_biquad_iir_filter.sv
